// File: rtl/core/indexed_array_with_insert_erase_defines.svh
`ifndef INDEXED_ARRAY_WITH_INSERT_ERASE_DEFINES_SVH
`define INDEXED_ARRAY_WITH_INSERT_ERASE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, disabled in reset.
`define IAIE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iaie assertion failed");

// Next-cycle implication, clocked on clk_i, disabled in reset.
`define IAIE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iaie assertion failed");

`endif

// File: rtl/core/iaie_pkg.sv
package iaie_pkg;

  localparam int unsigned DEPTH      = 256;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned FIELD_W    = 9;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned SUM_W      = ((CNT_W > FIELD_W) ? CNT_W : FIELD_W) + 1;

  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned S_TUSER_W = 3;
  localparam int unsigned M_TDATA_W = 48;
  localparam int unsigned M_TUSER_W = 2;

  typedef enum logic [2:0] {
    REQ_APPEND,
    REQ_REMOVE,
    REQ_READ,
    REQ_WRITE,
    REQ_INSERT,
    REQ_ERASE,
    REQ_RESIZE,
    REQ_CLEAR
  } req_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY,
    ST_BAD
  } status_e;

  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_LOAD,
    UOP_CHECK,
    UOP_MOVE,
    UOP_FSET,
    UOP_FILL,
    UOP_EMIT
  } uop_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_BAD,
    COND_REM_NZ,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    uop_e uop;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic bad;
    logic rem_nz;
    logic out_busy;
  } flags_t;

endpackage

// File: rtl/core/iaie_seq.sv
`include "indexed_array_with_insert_erase_defines.svh"

module iaie_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  iaie_pkg::flags_t flags_i,
  output iaie_pkg::ctrl_t  ctrl_o
);
  import iaie_pkg::*;

  localparam int unsigned STEP_W = 3;

  localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MOVE  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_FSET  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_FILL  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_RET   = 3'd6;

  typedef struct packed {
    uop_e              uop;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Control store: taken condition jumps to target, else falls through.
  function automatic ucode_t urom(input logic [STEP_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      STEP_IDLE:  w = '{uop: UOP_LOAD,  cond: COND_NO_INPUT, target: STEP_IDLE};
      STEP_CHECK: w = '{uop: UOP_CHECK, cond: COND_BAD,      target: STEP_EMIT};
      STEP_MOVE:  w = '{uop: UOP_MOVE,  cond: COND_REM_NZ,   target: STEP_MOVE};
      STEP_FSET:  w = '{uop: UOP_FSET,  cond: COND_NEVER,    target: STEP_IDLE};
      STEP_FILL:  w = '{uop: UOP_FILL,  cond: COND_REM_NZ,   target: STEP_FILL};
      STEP_EMIT:  w = '{uop: UOP_EMIT,  cond: COND_OUT_BUSY, target: STEP_EMIT};
      default:    w = '{uop: UOP_NOP,   cond: COND_ALWAYS,   target: STEP_IDLE};
    endcase
    return w;
  endfunction

  logic [STEP_W-1:0] upc_q, upc_d;
  ucode_t            cw;
  logic              take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= STEP_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  always_comb begin
    cw = urom(upc_q);
    unique case (cw.cond)
      COND_ALWAYS:   take = 1'b1;
      COND_NO_INPUT: take = !flags_i.in_valid;
      COND_BAD:      take = flags_i.bad;
      COND_REM_NZ:   take = flags_i.rem_nz;
      COND_OUT_BUSY: take = flags_i.out_busy;
      default:       take = 1'b0;
    endcase
    upc_d      = take ? cw.target : upc_q + STEP_W'(1);
    ctrl_o.uop = cw.uop;
  end

  `IAIE_ASSERT_NXT(a_check_ok_moves, upc_q == STEP_CHECK && !flags_i.bad, upc_q == STEP_MOVE)
  `IAIE_ASSERT_NXT(a_check_bad_emits, upc_q == STEP_CHECK && flags_i.bad, upc_q == STEP_EMIT)
  `IAIE_ASSERT_NXT(a_emit_done, upc_q == STEP_EMIT && !flags_i.out_busy, upc_q == STEP_RET)

endmodule

// File: rtl/core/iaie_dp.sv
`include "indexed_array_with_insert_erase_defines.svh"

module iaie_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  iaie_pkg::ctrl_t                    ctrl_i,
  output iaie_pkg::flags_t                   flags_o,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // position[8:0], end_position[17:9], amount[26:18], value[58:27], zero pad
  input  logic [iaie_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // req_type[2:0]
  input  logic [iaie_pkg::S_TUSER_W-1:0]     s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // read_data[31:0], fill_count[40:32], zero pad
  output logic [iaie_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  // status[1:0]
  output logic [iaie_pkg::M_TUSER_W-1:0]     m_axis_tuser_o
);
  import iaie_pkg::*;

  // captured request
  req_e                  kind_q;
  logic [FIELD_W-1:0]    pos_q, endp_q, amt_q;
  logic [DATA_WIDTH-1:0] val_q;

  logic [CNT_W-1:0]      cnt_q;
  status_e               st_q;

  // loop registers for move and fill; rem_q and dst_q serve both
  logic [ADDR_W-1:0]     src_q, dst_q;
  logic [CNT_W-1:0]      rem_q;
  logic                  up_q;
  logic                  wr_pend_q;

  // fill plan held from check to fill setup
  logic [ADDR_W-1:0]     fdst_q;
  logic [CNT_W-1:0]      fcnt_q;
  logic [CNT_W-1:0]      ncnt_q;

  // output register
  logic                  m_valid_q;
  status_e               m_st_q;
  logic [VALUE_W-1:0]    m_rdata_q;
  logic [FIELD_W-1:0]    m_fill_q;

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] mem_rdata_q;
  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata;

  // check results
  status_e               chk_st;
  logic [CNT_W-1:0]      chk_mrem, chk_fcnt, chk_ncnt;
  logic [ADDR_W-1:0]     chk_msrc, chk_mdst, chk_fdst;
  logic                  chk_up;
  logic [SUM_W-1:0]      n_w, pos_w, endp_w, amt_w, dep_w;

  logic                  load, rem_nz, out_busy, emit;

  assign load     = ctrl_i.uop == UOP_LOAD && s_axis_tvalid_i;
  assign rem_nz   = rem_q != '0;
  assign out_busy = m_valid_q && !m_axis_tready_i;
  assign emit     = ctrl_i.uop == UOP_EMIT && !out_busy;

  always_comb begin
    n_w      = SUM_W'(cnt_q);
    pos_w    = SUM_W'(pos_q);
    endp_w   = SUM_W'(endp_q);
    amt_w    = SUM_W'(amt_q);
    dep_w    = SUM_W'(DEPTH);
    chk_st   = ST_OK;
    chk_mrem = '0;
    chk_msrc = '0;
    chk_mdst = '0;
    chk_up   = 1'b0;
    chk_fdst = '0;
    chk_fcnt = '0;
    chk_ncnt = cnt_q;
    unique case (kind_q)
      REQ_APPEND: begin
        if (n_w >= dep_w) begin
          chk_st = ST_FULL;
        end else begin
          chk_fdst = ADDR_W'(n_w);
          chk_fcnt = CNT_W'(1);
          chk_ncnt = CNT_W'(n_w + SUM_W'(1));
        end
      end
      REQ_REMOVE: begin
        if (cnt_q == '0) begin
          chk_st = ST_EMPTY;
        end else begin
          chk_ncnt = cnt_q - CNT_W'(1);
        end
      end
      REQ_READ: begin
        if (pos_w >= n_w) chk_st = ST_BAD;
      end
      REQ_WRITE: begin
        if (pos_w >= n_w) begin
          chk_st = ST_BAD;
        end else begin
          chk_fdst = ADDR_W'(pos_w);
          chk_fcnt = CNT_W'(1);
        end
      end
      REQ_INSERT: begin
        if (pos_w > n_w) begin
          chk_st = ST_BAD;
        end else if (n_w + amt_w > dep_w) begin
          chk_st = ST_FULL;
        end else if (amt_w != '0) begin
          chk_mrem = CNT_W'(n_w - pos_w);
          chk_msrc = ADDR_W'(n_w - SUM_W'(1));
          chk_mdst = ADDR_W'(n_w + amt_w - SUM_W'(1));
          chk_fdst = ADDR_W'(pos_w);
          chk_fcnt = CNT_W'(amt_w);
          chk_ncnt = CNT_W'(n_w + amt_w);
        end
      end
      REQ_ERASE: begin
        if (pos_w > endp_w || endp_w > n_w) begin
          chk_st = ST_BAD;
        end else if (endp_w != pos_w) begin
          chk_mrem = CNT_W'(n_w - endp_w);
          chk_msrc = ADDR_W'(endp_w);
          chk_mdst = ADDR_W'(pos_w);
          chk_up   = 1'b1;
          chk_ncnt = CNT_W'(n_w - (endp_w - pos_w));
        end
      end
      REQ_RESIZE: begin
        if (amt_w > dep_w) begin
          chk_st = ST_FULL;
        end else begin
          if (amt_w > n_w) begin
            chk_fdst = ADDR_W'(n_w);
            chk_fcnt = CNT_W'(amt_w - n_w);
          end
          chk_ncnt = CNT_W'(amt_w);
        end
      end
      REQ_CLEAR: begin
        chk_ncnt = '0;
      end
    endcase
  end

  // memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = src_q;
    mem_we    = 1'b0;
    mem_waddr = dst_q;
    mem_wdata = val_q;
    if (ctrl_i.uop == UOP_CHECK && kind_q == REQ_READ && chk_st == ST_OK) begin
      mem_re    = 1'b1;
      mem_raddr = ADDR_W'(pos_q);
    end else if (ctrl_i.uop == UOP_MOVE && rem_nz) begin
      mem_re = 1'b1;
    end
    if (wr_pend_q) begin
      mem_we    = 1'b1;
      mem_wdata = mem_rdata_q;
    end else if (ctrl_i.uop == UOP_FILL && rem_nz) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      wr_pend_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      wr_pend_q <= ctrl_i.uop == UOP_MOVE && rem_nz;
      if (ctrl_i.uop == UOP_FSET) cnt_q <= ncnt_q;
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= req_e'(s_axis_tuser_i);
      pos_q  <= s_axis_tdata_i[FIELD_W-1:0];
      endp_q <= s_axis_tdata_i[2*FIELD_W-1:FIELD_W];
      amt_q  <= s_axis_tdata_i[3*FIELD_W-1:2*FIELD_W];
      val_q  <= s_axis_tdata_i[3*FIELD_W+DATA_WIDTH-1:3*FIELD_W];
    end
    unique case (ctrl_i.uop)
      UOP_CHECK: begin
        st_q   <= chk_st;
        rem_q  <= chk_mrem;
        src_q  <= chk_msrc;
        dst_q  <= chk_mdst;
        up_q   <= chk_up;
        fdst_q <= chk_fdst;
        fcnt_q <= chk_fcnt;
        ncnt_q <= chk_ncnt;
      end
      UOP_MOVE: begin
        if (rem_nz) begin
          rem_q <= rem_q - CNT_W'(1);
          src_q <= up_q ? src_q + ADDR_W'(1) : src_q - ADDR_W'(1);
        end
      end
      UOP_FSET: begin
        rem_q <= fcnt_q;
        dst_q <= fdst_q;
      end
      UOP_FILL: begin
        if (rem_nz) begin
          rem_q <= rem_q - CNT_W'(1);
          dst_q <= dst_q + ADDR_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (wr_pend_q) dst_q <= up_q ? dst_q + ADDR_W'(1) : dst_q - ADDR_W'(1);
    if (emit) begin
      m_st_q    <= st_q;
      m_rdata_q <= (kind_q == REQ_READ && st_q == ST_OK) ? VALUE_W'(mem_rdata_q) : '0;
      m_fill_q  <= FIELD_W'(cnt_q);
    end
  end

  assign flags_o.in_valid = s_axis_tvalid_i;
  assign flags_o.bad      = chk_st != ST_OK;
  assign flags_o.rem_nz   = rem_nz;
  assign flags_o.out_busy = out_busy;

  assign s_axis_tready_o = ctrl_i.uop == UOP_LOAD;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = M_TDATA_W'({m_fill_q, m_rdata_q});
  assign m_axis_tuser_o  = m_st_q;

  `IAIE_ASSERT_IMP(a_one_writer, wr_pend_q, !(ctrl_i.uop == UOP_FILL && rem_nz))
  `IAIE_ASSERT_IMP(a_cnt_in_range, 1'b1, SUM_W'(cnt_q) <= SUM_W'(DEPTH))
  `IAIE_ASSERT_NXT(a_move_steps, ctrl_i.uop == UOP_MOVE && rem_nz,
                   rem_q == $past(rem_q) - CNT_W'(1) && wr_pend_q)

endmodule

// File: rtl/core/indexed_array_with_insert_erase.sv
// Fixed-depth ordered array (256 x 32-bit) with a fill count. One request per
// input transaction (append, remove last, read, write, insert copies, erase
// range, resize with fill, clear); each returns one output transaction with
// status, read data and the new count. Requests run one at a time under a
// small microprogram over a single-write, single-read element memory. A
// rejected request skips the shift and fill loops. An accepted one shifts M
// elements (count - position for insert, count - end_position for erase)
// and then writes F slots (1 for append and write, amount for insert,
// growth for resize), one element per cycle through the memory write port.
// A finished request waits to emit while the output register still holds
// a result that has not been taken. The next request is taken while the
// previous result still sits in the output register.
module indexed_array_with_insert_erase (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // position[8:0], end_position[17:9], amount[26:18], value[58:27], zero pad
  input  logic [iaie_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // req_type[2:0]
  input  logic [iaie_pkg::S_TUSER_W-1:0] s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // read_data[31:0], fill_count[40:32], zero pad
  output logic [iaie_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // status[1:0]
  output logic [iaie_pkg::M_TUSER_W-1:0] m_axis_tuser_o
);
  import iaie_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;

  iaie_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  iaie_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .flags_o         (flags),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// File: sim/indexed_array_with_insert_erase_tb.sv
module indexed_array_with_insert_erase_tb;
  import iaie_pkg::*;

  localparam int STORE_DEPTH = DEPTH;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_CYCLES = 2000;
  localparam int TAIL_CYCLES = 600;

  typedef struct {
    status_e     status;
    logic [31:0] rdata;
    logic [8:0]  count;
  } result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_valid = 1'b0;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 m_ready = 1'b0;
  logic                 s_axis_tready_o;
  logic                 m_axis_tvalid_o;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic [M_TUSER_W-1:0] m_axis_tuser_o;

  logic [31:0] shadow_elems [STORE_DEPTH];
  int          shadow_count = 0;
  result_t     pending_results [$];

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_until = 0;
  int cycle_cnt = 0;
  int error_cnt = 0;
  int checked_cnt = 0;
  int sent_cnt = 0;
  int kind_hits [8];

  indexed_array_with_insert_erase u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (cycle_cnt < hold_until) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Applies one request to the shadow array and returns the result it produces.
  function automatic result_t apply_request(req_e kind, logic [8:0] pos, logic [8:0] endp,
                                            logic [8:0] amt, logic [31:0] val);
    result_t r;
    int n, p, e, a, d, i;
    n = shadow_count;
    p = pos;
    e = endp;
    a = amt;
    r.status = ST_OK;
    r.rdata = '0;
    case (kind)
      REQ_APPEND: begin
        if (n >= STORE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_elems[n] = val;
          shadow_count = n + 1;
        end
      end
      REQ_REMOVE: begin
        if (n == 0) r.status = ST_EMPTY;
        else shadow_count = n - 1;
      end
      REQ_READ: begin
        if (p >= n) r.status = ST_BAD;
        else r.rdata = shadow_elems[p];
      end
      REQ_WRITE: begin
        if (p >= n) r.status = ST_BAD;
        else shadow_elems[p] = val;
      end
      REQ_INSERT: begin
        if (p > n) begin
          r.status = ST_BAD;
        end else if (n + a > STORE_DEPTH) begin
          r.status = ST_FULL;
        end else if (a != 0) begin
          for (i = n + a; i > p + a; i--) shadow_elems[i-1] = shadow_elems[i-1-a];
          for (i = p; i < p + a; i++) shadow_elems[i] = val;
          shadow_count = n + a;
        end
      end
      REQ_ERASE: begin
        if (p > e || e > n) begin
          r.status = ST_BAD;
        end else begin
          d = e - p;
          for (i = p; i + d < n; i++) shadow_elems[i] = shadow_elems[i+d];
          shadow_count = n - d;
        end
      end
      REQ_RESIZE: begin
        if (a > STORE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = n; i < a; i++) shadow_elems[i] = val;
          shadow_count = a;
        end
      end
      REQ_CLEAR: begin
        shadow_count = 0;
      end
    endcase
    r.count = shadow_count[8:0];
    return r;
  endfunction

  task automatic send_req(req_e kind, int pos, int endp, int amt, logic [31:0] val);
    result_t r;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {5'd0, val, 9'(amt), 9'(endp), 9'(pos)};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    r = apply_request(kind, 9'(pos), 9'(endp), 9'(amt), val);
    pending_results = {pending_results, r};
    kind_hits[int'(kind)]++;
    sent_cnt++;
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Mostly well-formed requests against the current fill; a slice of stray indexes.
  task automatic random_req();
    int n, sel, pos, endp, amt;
    req_e kind;
    logic [31:0] val;
    n = shadow_count;
    val = $urandom();
    pos = $urandom_range(0, STORE_DEPTH);
    endp = $urandom_range(0, STORE_DEPTH);
    amt = $urandom_range(0, STORE_DEPTH);
    sel = $urandom_range(0, 99);
    if (sel < 20) kind = REQ_APPEND;
    else if (sel < 28) kind = REQ_REMOVE;
    else if (sel < 46) kind = REQ_READ;
    else if (sel < 58) kind = REQ_WRITE;
    else if (sel < 72) kind = REQ_INSERT;
    else if (sel < 84) kind = REQ_ERASE;
    else if (sel < 94) kind = REQ_RESIZE;
    else kind = REQ_CLEAR;
    if ($urandom_range(0, 99) >= 10) begin
      case (kind)
        REQ_READ, REQ_WRITE: begin
          if (n > 0 && $urandom_range(0, 9) != 0) pos = $urandom_range(0, n - 1);
          else pos = $urandom_range(n, STORE_DEPTH);
        end
        REQ_INSERT: begin
          pos = $urandom_range(0, n);
          amt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, STORE_DEPTH)
                                             : $urandom_range(0, 6);
        end
        REQ_ERASE: begin
          pos = $urandom_range(0, n);
          endp = $urandom_range(pos, (pos + 8 < n) ? pos + 8 : n);
        end
        REQ_RESIZE: begin
          if ($urandom_range(0, 29) == 0) amt = STORE_DEPTH;
          else amt = $urandom_range(0, 24);
        end
        default: ;
      endcase
    end
    send_req(kind, pos, endp, amt, val);
  endtask

  task automatic test_directed();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    send_req(REQ_CLEAR, 0, 0, 0, 32'h0);
    send_req(REQ_REMOVE, 0, 0, 0, 32'h0);
    send_req(REQ_READ, 0, 0, 0, 32'h0);
    send_req(REQ_WRITE, 0, 0, 0, 32'h1111_1111);
    send_req(REQ_ERASE, 0, 1, 0, 32'h0);
    send_req(REQ_INSERT, 1, 0, 1, 32'h2222_2222);
    send_req(REQ_INSERT, 0, 0, 0, 32'h3333_3333);
    send_req(REQ_APPEND, 0, 0, 0, 32'h0000_0000);
    send_req(REQ_APPEND, 0, 0, 0, 32'hFFFF_FFFF);
    send_req(REQ_WRITE, 0, 0, 0, 32'hA5A5_A5A5);
    send_req(REQ_READ, 0, 0, 0, 32'h0);
    send_req(REQ_INSERT, 1, 0, 3, 32'h1234_5678);
    send_req(REQ_READ, 4, 0, 0, 32'h0);
    send_req(REQ_ERASE, 3, 2, 0, 32'h0);
    send_req(REQ_ERASE, 1, 3, 0, 32'h0);
    send_req(REQ_INSERT, 0, 0, 256, 32'h4444_4444);
    send_req(REQ_RESIZE, 0, 0, 257, 32'h5555_5555);
    send_req(REQ_RESIZE, 0, 0, 256, 32'h5A5A_5A5A);
    send_req(REQ_APPEND, 0, 0, 0, 32'h6666_6666);
    send_req(REQ_INSERT, 256, 0, 1, 32'h7777_7777);
    send_req(REQ_READ, 255, 0, 0, 32'h0);
    send_req(REQ_READ, 256, 0, 0, 32'h0);
    send_req(REQ_ERASE, 0, 256, 0, 32'h0);
    send_req(REQ_INSERT, 0, 0, 256, 32'hC3C3_C3C3);
    send_req(REQ_RESIZE, 0, 0, 2, 32'h8888_8888);
    send_req(REQ_RESIZE, 0, 0, 5, 32'h9999_9999);
    send_req(REQ_REMOVE, 0, 0, 0, 32'h0);
    send_req(REQ_CLEAR, 0, 0, 0, 32'h0);
    wait_drained();
  endtask

  task automatic test_random(int n_items, int idle_pct, int stall_pct);
    src_idle_pct = idle_pct;
    snk_stall_pct = stall_pct;
    repeat (n_items) random_req();
    wait_drained();
  endtask

  // Output held off long enough that the block backs up and stalls its input.
  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_until = cycle_cnt + HOLD_CYCLES;
    repeat (16) random_req();
    wait_drained();
  endtask

  // Long shifts with the store near its depth.
  task automatic test_near_full();
    src_idle_pct = 12;
    snk_stall_pct = 12;
    send_req(REQ_RESIZE, 0, 0, 250, $urandom());
    repeat (40) begin
      if ($urandom_range(0, 3) == 0) send_req(REQ_APPEND, 0, 0, 0, $urandom());
      else random_req();
    end
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: status %0d data %h count %0d",
               m_axis_tuser_o, m_axis_tdata_o[31:0], m_axis_tdata_o[40:32]);
        error_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        checked_cnt++;
        if (m_axis_tuser_o !== exp_r.status) begin
          $error("status mismatch: expected %0d, got %0d", exp_r.status, m_axis_tuser_o);
          error_cnt++;
        end
        if (m_axis_tdata_o[31:0] !== exp_r.rdata) begin
          $error("read_data mismatch: expected %h, got %h", exp_r.rdata,
                 m_axis_tdata_o[31:0]);
          error_cnt++;
        end
        if (m_axis_tdata_o[40:32] !== exp_r.count) begin
          $error("fill_count mismatch: expected %0d, got %0d", exp_r.count,
                 m_axis_tdata_o[40:32]);
          error_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(450, 0, 0);
    test_random(450, 84, 0);
    test_random(450, 0, 84);
    test_random(450, 12, 12);
    test_backpressure();
    test_near_full();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("%0d requests, %0d results checked (append %0d, remove %0d, read %0d, write %0d,",
             sent_cnt, checked_cnt, kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3]);
    $display("insert %0d, erase %0d, resize %0d, clear %0d); idle mixes, hold-off, near full",
             kind_hits[4], kind_hits[5], kind_hits[6], kind_hits[7]);
    if (error_cnt == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: indexed_array_with_insert_erase.f
+incdir+rtl/core
rtl/core/iaie_pkg.sv
rtl/core/iaie_seq.sv
rtl/core/iaie_dp.sv
rtl/core/indexed_array_with_insert_erase.sv
sim/indexed_array_with_insert_erase_tb.sv
